[hw/rtl/ukrt_pkg.sv]
`default_nettype none
// ============================================================================
// ukrt_pkg
// Shared types and constants of the unique-key record table.
// ============================================================================
package ukrt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NAME_BYTES  = 29;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP_NUM   = 3'd1;
    localparam logic [2:0] ST_DUP_NAME  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] part_number;
        logic [63:0]        name_bytes_lo;
        logic [63:0]        name_bytes_mid;
        logic [63:0]        name_bytes_upper;
        logic [39:0]        name_bytes_top;
        logic signed [31:0] stock_quantity;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] found_quantity;
        logic [63:0]        found_name_lo;
        logic [63:0]        found_name_mid;
        logic [63:0]        found_name_upper;
        logic [39:0]        found_name_top;
    } out_word_t;

    // Byte i of the name sits at bits 8*i+7 .. 8*i.
    typedef struct packed {
        logic [39:0] top;
        logic [63:0] upper;
        logic [63:0] mid;
        logic [63:0] lo;
    } name_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key;
        name_t       name;
        logic [31:0] quantity;
    } cmd_t;

    typedef struct packed {
        logic [31:0] key;
        name_t       name;
    } rec_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_COMMIT
    } back_state_t;

endpackage : ukrt_pkg
`default_nettype wire

[hw/rtl/ukrt_front.sv]
`default_nettype none
// ============================================================================
// ukrt_front
// Accepts input words, cuts the name at its first zero byte and holds the
// commands in a two-entry queue in front of the table engine.
// ============================================================================
module ukrt_front
    import ukrt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_word_t item,
    output cmd_t          cmd,
    output logic          cmd_valid,
    input  wire logic     cmd_ready
);

    localparam int NB = NAME_BYTES;

    name_t             raw_name;
    name_t             canon_name;
    logic [NB-1:0]     nz;
    logic [NB-1:0]     keep;
    cmd_t              cmd_in;

    cmd_t              q_mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign raw_name = '{top: item.name_bytes_top, upper: item.name_bytes_upper,
                        mid: item.name_bytes_mid, lo: item.name_bytes_lo};

    // A byte survives only if every byte before it is nonzero.
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            nz[i] = (raw_name[8*i +: 8] != 8'd0);
        end
        for (int i = 0; i < NB; i++)
        begin
            keep[i] = &(nz | ~((NB'(1) << i) - NB'(1)));
        end
        canon_name = '0;
        for (int i = 0; i < NB; i++)
        begin
            canon_name[8*i +: 8] = keep[i] ? raw_name[8*i +: 8] : 8'd0;
        end
    end

    assign cmd_in = '{opcode: item.opcode, key: item.part_number, name: canon_name,
                      quantity: item.stock_quantity};

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule : ukrt_front
`default_nettype wire

[hw/rtl/ukrt_back.sv]
`default_nettype none
// ============================================================================
// ukrt_back
// Table engine: scans the filled entries one per cycle, then commits the
// insert or update and loads the result word into the output register.
// ============================================================================
module ukrt_back
    import ukrt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    cmd,
    input  wire logic    cmd_valid,
    output logic         cmd_ready,
    output out_word_t    result,
    output logic         empty,
    input  wire logic    pop
);

    rec_t        rec_mem [TABLE_DEPTH];
    logic [31:0] qty_mem [TABLE_DEPTH];
    rec_t        rd_rec_reg;
    logic [31:0] rd_qty_reg;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic        pend_reg, pend_next;
    logic        found_reg, found_next;
    logic        dupname_reg, dupname_next;
    out_word_t   res_reg;
    logic        res_vld_reg, res_vld_next;

    logic        start, issue, commit_go, hit, scan_done, key_eq, name_eq;
    logic        table_full;
    logic [ADDR_W-1:0] hit_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic        rec_we, qty_we;
    logic [ADDR_W-1:0] wr_addr;
    out_word_t   res_new;
    logic        pop_go;

    assign key_eq    = (rd_rec_reg.key == cmd_reg.key);
    assign name_eq   = (rd_rec_reg.name == cmd_reg.name);
    assign hit       = pend_reg && (key_eq || ((cmd_reg.opcode == OP_INSERT) && name_eq));
    assign scan_done = !hit && (idx_reg == count_reg);
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign hit_addr  = ADDR_W'(idx_reg - CNT_W'(1));
    assign rd_addr   = idx_reg[ADDR_W-1:0];
    assign pop_go    = pop && res_vld_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (hit || scan_done)
                begin
                    state_next = BK_COMMIT;
                end
            end
            BK_COMMIT:
            begin
                if (!res_vld_reg || pop)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        start     = 1'b0;
        issue     = 1'b0;
        commit_go = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                start = cmd_valid;
            end
            BK_SCAN:
            begin
                issue = !hit && (idx_reg != count_reg);
            end
            BK_COMMIT:
            begin
                commit_go = !res_vld_reg || pop;
            end
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    assign cmd_ready = (state_reg == BK_IDLE);

    // Commit: table writes and the result word.
    always_comb
    begin
        res_new        = '0;
        res_new.status = ST_NOT_FOUND;
        rec_we         = 1'b0;
        qty_we         = 1'b0;
        wr_addr        = hit_addr;
        count_next     = count_reg;
        unique case (cmd_reg.opcode)
            OP_INSERT:
            begin
                wr_addr = count_reg[ADDR_W-1:0];
                if (found_reg)
                begin
                    res_new.status = dupname_reg ? ST_DUP_NAME : ST_DUP_NUM;
                end
                else if (table_full)
                begin
                    res_new.status = ST_FULL;
                end
                else
                begin
                    res_new.status = ST_OK;
                    rec_we         = commit_go;
                    qty_we         = commit_go;
                    if (commit_go)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            OP_SEARCH:
            begin
                if (found_reg)
                begin
                    res_new.status           = ST_OK;
                    res_new.found_quantity   = rd_qty_reg;
                    res_new.found_name_lo    = rd_rec_reg.name.lo;
                    res_new.found_name_mid   = rd_rec_reg.name.mid;
                    res_new.found_name_upper = rd_rec_reg.name.upper;
                    res_new.found_name_top   = rd_rec_reg.name.top;
                end
            end
            OP_UPDATE:
            begin
                if (found_reg)
                begin
                    res_new.status = ST_OK;
                    qty_we         = commit_go;
                end
            end
            default:
            begin
                res_new.status = ST_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        found_next   = found_reg;
        dupname_next = dupname_reg;
        if (start)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
        end
        else if (issue)
        begin
            idx_next  = idx_reg + CNT_W'(1);
            pend_next = 1'b1;
        end
        if (state_reg == BK_SCAN)
        begin
            found_next   = hit;
            dupname_next = !key_eq;
        end
        if (commit_go)
        begin
            res_vld_next = 1'b1;
        end
        else if (pop_go)
        begin
            res_vld_next = 1'b0;
        end
        else
        begin
            res_vld_next = res_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            dupname_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            dupname_reg <= dupname_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
        end
        if (commit_go)
        begin
            res_reg <= res_new;
        end
    end

    // Record and quantity stores; read data is held while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[wr_addr] <= '{key: cmd_reg.key, name: cmd_reg.name};
        end
        if (issue)
        begin
            rd_rec_reg <= rec_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (qty_we)
        begin
            qty_mem[wr_addr] <= cmd_reg.quantity;
        end
        if (issue)
        begin
            rd_qty_reg <= qty_mem[rd_addr];
        end
    end

    assign result = res_reg;
    assign empty  = !res_vld_reg;

endmodule : ukrt_back
`default_nettype wire

[hw/rtl/unique_key_record_table.sv]
`default_nettype none
// ============================================================================
// unique_key_record_table
// Record table of part numbers, names and quantities with insert, search and
// update, searched linearly over the filled entries.
// ============================================================================
//  channel   direction   handshake            word
//  item      in          push / full          in_word_t
//  result    out         empty / pop          out_word_t
//
//  An operation passes through the table engine as a start, a scan of the
//  filled entries through the single read port of the stores, and a commit.
//  Any scan stops early at its first match, a duplicate for an insert.
//  Reset empties the table at once; no clearing pass. Two commands queue
//  in front of the engine, and a finished result waits in the output
//  register while the next command is already scanning; that command's
//  commit waits until the register is popped.
module unique_key_record_table
    import ukrt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_word_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_word_t     result
);

    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_ready;

    ukrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    ukrt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule : unique_key_record_table
`default_nettype wire

[tb/unique_key_record_table_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// unique_key_record_table_test
// Self-checking bench for the record table. It starts with a short directed
// run over empty-table misses, key and name extremes, duplicate detection and
// name truncation. A long random run then fills the table to capacity and
// keeps hitting it with searches, updates and rejected inserts. A local table
// model predicts every result word. Both queue interfaces idle at random.
// ============================================================================
module unique_key_record_table_test;
    import ukrt_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RANDOM_CMDS = 700;
    localparam int         STALL_LIMIT = 2000;
    localparam int         TAIL_CYCLES = 2 * (TABLE_DEPTH + 3) + 20;

    typedef struct {
        in_word_t word;
        bit       drain;
    } queued_cmd_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    in_word_t  item = '0;
    logic      full;
    logic      empty;
    out_word_t result;

    unique_key_record_table uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Local copy of the table contents.
    logic [31:0] rec_key  [TABLE_DEPTH];
    name_t       rec_name [TABLE_DEPTH];
    logic [31:0] rec_qty  [TABLE_DEPTH];
    int          rec_count = 0;

    queued_cmd_t cmd_queue[$];
    out_word_t   expected_results[$];
    logic [31:0] key_pool[$];
    name_t       name_pool[$];
    int          name_len_pool[$];

    int  total_cmds = 0;
    int  cmds_accepted = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  stall_cycles = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  cmd_taken = 1'b0;
    bit  result_taken = 1'b0;
    int  status_seen[5] = '{default: 0};
    out_word_t want_res;
    out_word_t new_res;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Only the bytes ahead of the first zero byte belong to the name.
    function automatic name_t cut_name(in_word_t w);
        name_t raw;
        name_t nm;
        bit    ended;
        raw = {w.name_bytes_top, w.name_bytes_upper, w.name_bytes_mid, w.name_bytes_lo};
        nm = '0;
        ended = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (raw[8*i +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                nm[8*i +: 8] = raw[8*i +: 8];
        end
        return nm;
    endfunction

    task automatic run_table_op(input in_word_t w, output out_word_t r);
        name_t nm;
        bit    hit;
        int    i;
        nm = cut_name(w);
        hit = 1'b0;
        r = '0;
        r.status = ST_NOT_FOUND;
        case (w.opcode)
            OP_INSERT:
            begin
                r.status = ST_OK;
                for (i = 0; i < rec_count && !hit; i++)
                begin
                    if (rec_key[i] == w.part_number)
                    begin
                        r.status = ST_DUP_NUM;
                        hit = 1'b1;
                    end
                    else if (rec_name[i] == nm)
                    begin
                        r.status = ST_DUP_NAME;
                        hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    if (rec_count >= TABLE_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        rec_key[rec_count] = w.part_number;
                        rec_name[rec_count] = nm;
                        rec_qty[rec_count] = w.stock_quantity;
                        rec_count++;
                    end
                end
            end
            OP_SEARCH:
            begin
                for (i = 0; i < rec_count && !hit; i++)
                begin
                    if (rec_key[i] == w.part_number)
                    begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.found_quantity = rec_qty[i];
                        r.found_name_lo = rec_name[i].lo;
                        r.found_name_mid = rec_name[i].mid;
                        r.found_name_upper = rec_name[i].upper;
                        r.found_name_top = rec_name[i].top;
                    end
                end
            end
            OP_UPDATE:
            begin
                for (i = 0; i < rec_count && !hit; i++)
                begin
                    if (rec_key[i] == w.part_number)
                    begin
                        hit = 1'b1;
                        rec_qty[i] = w.stock_quantity;
                        r.status = ST_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    // Every so often both sides run flat out for a stretch.
    function automatic int draw_wait(int n);
        if ((n % 160) < 30)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    function automatic name_t make_name(int len, bit any_bytes);
        name_t nm;
        nm = '0;
        for (int i = 0; i < len; i++)
            nm[8*i +: 8] = 8'($urandom_range(any_bytes ? 0 : 1, 255));
        return nm;
    endfunction

    // Junk after the terminating zero byte, which the block has to ignore.
    function automatic name_t add_tail(name_t nm, int len);
        name_t r;
        r = nm;
        for (int j = len + 1; j < NAME_BYTES; j++)
            r[8*j +: 8] = 8'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic queue_cmd(input logic [1:0] op, input logic [31:0] key, input name_t nm,
                             input logic [31:0] qty, input bit drain);
        queued_cmd_t c;
        c.word.opcode = op;
        c.word.part_number = key;
        c.word.name_bytes_lo = nm.lo;
        c.word.name_bytes_mid = nm.mid;
        c.word.name_bytes_upper = nm.upper;
        c.word.name_bytes_top = nm.top;
        c.word.stock_quantity = qty;
        c.drain = drain;
        cmd_queue.push_back(c);
        total_cmds++;
    endtask

    // Sampling side: accepted words on both channels, plus the stall watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result word with status %0d", result.status);
                    mismatches++;
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    check_field("status", 64'(want_res.status), 64'(result.status));
                    check_field("found_quantity", {32'b0, want_res.found_quantity},
                                {32'b0, result.found_quantity});
                    check_field("found_name_lo", want_res.found_name_lo, result.found_name_lo);
                    check_field("found_name_mid", want_res.found_name_mid, result.found_name_mid);
                    check_field("found_name_upper", want_res.found_name_upper,
                                result.found_name_upper);
                    check_field("found_name_top", 64'(want_res.found_name_top),
                                64'(result.found_name_top));
                    if (want_res.status <= ST_FULL)
                        status_seen[want_res.status]++;
                end
                results_seen++;
                result_taken = 1'b1;
            end
            if (push && !full)
            begin
                run_table_op(item, new_res);
                expected_results.push_back(new_res);
                cmds_accepted++;
                cmd_taken = 1'b1;
            end
            if ((pop && !empty) || (push && !full))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Command driver.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_taken)
            begin
                cmd_taken = 1'b0;
                void'(cmd_queue.pop_front());
                send_wait = draw_wait(cmds_accepted);
            end
            if (send_wait > 0)
            begin
                send_wait--;
                push <= 1'b0;
            end
            else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain && expected_results.size() != 0))
            begin
                push <= 1'b1;
                item <= cmd_queue[0].word;
            end
            else
                push <= 1'b0;
        end
    end

    // Result reader.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                recv_wait = draw_wait(results_seen);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        name_t       n_a;
        name_t       n_ones;
        name_t       nm;
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] qty;
        int          roll;
        int          len;
        int          pick;
        bit          early;
        bit          fresh;
        bit          timed_out;

        n_a = '0;
        n_a.lo[7:0] = 8'h41;
        n_ones = '1;
        timed_out = 1'b0;

        // Directed part.
        queue_cmd(OP_SEARCH, 32'h0, '0, 32'h0, 1'b0);
        queue_cmd(OP_UPDATE, 32'h1, n_a, 32'h5, 1'b0);
        queue_cmd(OP_UNUSED, 32'hffffffff, n_ones, 32'hffffffff, 1'b0);
        queue_cmd(OP_INSERT, 32'h80000000, n_a, 32'h80000000, 1'b0);
        queue_cmd(OP_INSERT, 32'h7fffffff, n_ones, 32'h7fffffff, 1'b0);
        queue_cmd(OP_INSERT, 32'h0, add_tail('0, 0), 32'hffffffff, 1'b0);
        queue_cmd(OP_INSERT, 32'h0, make_name(5, 1'b0), 32'h1, 1'b0);
        queue_cmd(OP_INSERT, 32'h5, n_ones, 32'h2, 1'b0);
        queue_cmd(OP_INSERT, 32'h6, add_tail(n_a, 1), 32'h3, 1'b0);
        queue_cmd(OP_INSERT, 32'h7, '0, 32'h4, 1'b0);
        // Earlier entry wins: a name hit on entry 0 beats a key hit on entry 1.
        queue_cmd(OP_INSERT, 32'h7fffffff, n_a, 32'h6, 1'b0);
        queue_cmd(OP_INSERT, 32'h80000000, n_ones, 32'h7, 1'b0);
        queue_cmd(OP_SEARCH, 32'h80000000, make_name(29, 1'b1), 32'h0, 1'b0);
        queue_cmd(OP_SEARCH, 32'h7fffffff, '0, 32'h0, 1'b0);
        queue_cmd(OP_SEARCH, 32'h0, '0, 32'h0, 1'b0);
        queue_cmd(OP_UPDATE, 32'h7fffffff, '0, 32'h0, 1'b0);
        queue_cmd(OP_SEARCH, 32'h7fffffff, '0, 32'h0, 1'b0);
        queue_cmd(OP_UPDATE, 32'd12345, '0, 32'h9, 1'b0);
        queue_cmd(OP_SEARCH, 32'hffffffff, '0, 32'h0, 1'b0);
        queue_cmd(OP_INSERT, 32'h8, make_name(28, 1'b0), 32'd42, 1'b0);
        queue_cmd(OP_INSERT, 32'h9, add_tail(make_name(7, 1'b0), 7), 32'd43, 1'b0);
        queue_cmd(OP_SEARCH, 32'h8, '0, 32'h0, 1'b0);
        queue_cmd(OP_SEARCH, 32'h9, '0, 32'h0, 1'b0);
        queue_cmd(OP_UPDATE, 32'h0, '0, 32'h80000000, 1'b0);
        queue_cmd(OP_SEARCH, 32'h0, '0, 32'h0, 1'b0);
        key_pool = '{32'h0, 32'h80000000, 32'h7fffffff, 32'h8, 32'h9};
        name_pool = '{n_a};
        name_len_pool = '{1};

        // Random part. The early stretch leans on fresh inserts so the table fills up.
        for (int k = 0; k < RANDOM_CMDS; k++)
        begin
            early = (k < 150);
            roll = $urandom_range(0, 99);
            if (roll < (early ? 70 : 35))
                op = OP_INSERT;
            else if (roll < (early ? 85 : 65))
                op = OP_SEARCH;
            else if (roll < 95)
                op = OP_UPDATE;
            else
                op = OP_UNUSED;

            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: qty = 32'h80000000;
                    1: qty = 32'h7fffffff;
                    2: qty = 32'h0;
                    default: qty = 32'hffffffff;
                endcase
            end
            else
                qty = $urandom;

            if (op == OP_INSERT)
            begin
                fresh = ($urandom_range(0, 99) < (early ? 75 : 30));
                if (fresh || $urandom_range(0, 1) == 0)
                begin
                    key = $urandom;
                    key_pool.push_back(key);
                end
                else
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                if (fresh || $urandom_range(0, 1) == 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        nm = make_name(NAME_BYTES, 1'b1);
                        len = NAME_BYTES;
                    end
                    else
                    begin
                        len = $urandom_range(1, NAME_BYTES);
                        nm = make_name(len, 1'b0);
                        name_pool.push_back(nm);
                        name_len_pool.push_back(len);
                    end
                end
                else
                begin
                    pick = $urandom_range(0, name_pool.size() - 1);
                    nm = name_pool[pick];
                    len = name_len_pool[pick];
                end
                if (len < NAME_BYTES && $urandom_range(0, 9) < 3)
                    nm = add_tail(nm, len);
            end
            else
            begin
                if ($urandom_range(0, 4) != 0)
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else
                    key = $urandom;
                nm = make_name(NAME_BYTES, 1'b1);
            end
            queue_cmd(op, key, nm, qty, (k == 0) || (k % 150 == 75));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!timed_out && !(cmds_accepted == total_cmds && expected_results.size() == 0))
        begin
            @(negedge clk);
            if (stall_cycles >= STALL_LIMIT)
                timed_out = 1'b1;
        end

        if (timed_out)
        begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAIL unique_key_record_table");
            $finish;
        end
        else
        begin
            repeat (TAIL_CYCLES) @(negedge clk);
            $display("%0d commands: %0d ok, %0d dup number, %0d dup name, %0d missing, %0d full",
                     results_seen, status_seen[ST_OK], status_seen[ST_DUP_NUM],
                     status_seen[ST_DUP_NAME], status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
            $display("table held %0d of %0d records at the end", rec_count, TABLE_DEPTH);
            if (mismatches == 0)
                $display("PASS unique_key_record_table");
            else
                $display("FAIL unique_key_record_table");
            $finish;
        end
    end

endmodule

[unique_key_record_table.f]
hw/rtl/ukrt_pkg.sv
hw/rtl/ukrt_front.sv
hw/rtl/ukrt_back.sv
hw/rtl/unique_key_record_table.sv
tb/unique_key_record_table_test.sv
